FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the RTL of the sorted expiry timer block.
// Depends on nothing; take it by include where concurrent checks are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge, quiet while reset is high.
`define SETIMER_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every rising clock edge, reset included.
`define SETIMER_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/core/setimer_pkg.sv
// Types, sizes and codes of the sorted expiry timer block.
// Used by the RAM wrapper sizing and by the top level; depends on nothing.
package setimer_pkg;

   localparam int NUM_TIMERS = 64;
   localparam int TIME_WIDTH = 32;
   localparam int MAX_POP    = 64;
   localparam int ID_W       = 6;
   localparam int IN_TIME_W  = 32;
   localparam int ADDR_W     = $clog2(NUM_TIMERS);
   localparam int COUNT_W    = $clog2(NUM_TIMERS + 1);
   localparam int RAM_DEPTH  = 2 ** ADDR_W;
   localparam int ENTRY_W    = TIME_WIDTH + ID_W;

   typedef logic [TIME_WIDTH-1:0] time_type;
   typedef logic [ID_W-1:0]       id_type;
   typedef logic [ADDR_W-1:0]     addr_type;
   typedef logic [COUNT_W-1:0]    count_type;
   typedef logic [1:0]            status_type;

   // One entry of the ordered list: expiry and owning slot id
   typedef struct packed {
      time_type expiry;
      id_type   id;
   } entry_type;

   typedef enum logic [1:0] {
      CMD_ADD    = 2'd0,
      CMD_ADJUST = 2'd1,
      CMD_DELETE = 2'd2,
      CMD_TICK   = 2'd3
   } cmd_type;

   localparam status_type STATUS_OK       = 2'd0;
   localparam status_type STATUS_ACTIVE   = 2'd1;
   localparam status_type STATUS_INACTIVE = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INS_INIT,
      ST_INS_WALK,
      ST_INS_HEAD,
      ST_RM_WALK,
      ST_TICK
   } state_type;

   // Take the low TIME_WIDTH bits of a 32-bit time, zero-extending if wider
   function automatic time_type to_time(logic [IN_TIME_W-1:0] value);
      logic [TIME_WIDTH+IN_TIME_W-1:0] wide;
      wide = {{TIME_WIDTH{1'b0}}, value};
      return wide[TIME_WIDTH-1:0];
   endfunction

   // Map a slot id onto a slot index
   function automatic addr_type to_slot(id_type id);
      logic [ADDR_W+ID_W-1:0] wide;
      wide = {{ADDR_W{1'b0}}, id};
      return wide[ADDR_W-1:0];
   endfunction

   function automatic logic id_in_range(id_type id);
      return 32'(id) < NUM_TIMERS;
   endfunction

endpackage

FILE: rtl/core/setimer_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing.
module setimer_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and read; read data is registered and comes out on the cycle after the address
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/core/sorted_expiry_timer_table.sv
// Sorted expiry timer list: top level with control sequencer and status bits.
// Depends on setimer_pkg, setimer_ram and assert_macros.svh.
//
// Usage: drive req_cmd, req_timer_id, req_expire_time and req_now_time with
// start high; the command beat is taken on a rising edge where busy is low.
// Every result beat is shown for one cycle with rsp_valid high; rsp_last marks
// the final beat of a command. The receiver cannot hold results off.
// Entries sit in expiry order in one RAM used as a ring starting at a head
// pointer; each RAM entry holds the expiry and the slot id.
// Steps per command (at most one RAM read per cycle):
//   error of any command: result registered at accept, busy never rises.
//   add: a backward walk that shifts later entries up.
//   delete: a forward walk that finds the id and shifts down.
//   adjust: delete walk followed by the add walk.
//   tick: pops expired head entries, up to MAX_POP, one beat per popped entry;
//   popping only moves the head pointer.
// Reset clears the entry count, the head pointer and all slot active bits;
// the RAM needs no clearing since only entries below the count are used.
module sorted_expiry_timer_table
   import setimer_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic [1:0]           req_cmd,
   input  logic [ID_W-1:0]      req_timer_id,
   input  logic [IN_TIME_W-1:0] req_expire_time,
   input  logic [IN_TIME_W-1:0] req_now_time,
   output logic                 rsp_valid,
   output logic [1:0]           rsp_status,
   output logic                 rsp_is_expiry,
   output logic [ID_W-1:0]      rsp_expired_id,
   output logic                 rsp_last
);

`include "assert_macros.svh"

   // Control state
   state_type             state_ff, state_in;
   count_type             count_ff, count_in;
   addr_type              head_ff, head_in;
   logic [NUM_TIMERS-1:0] slot_active_ff, slot_active_in;
   logic                  pend_ff, pend_in;
   logic                  found_ff, found_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   // Command and walk payload
   cmd_type    cmd_ff, cmd_in;
   id_type     id_ff, id_in;
   time_type   exp_ff, exp_in;
   time_type   now_ff, now_in;
   count_type  idx_ff, idx_in;
   id_type     pend_id_ff, pend_id_in;
   status_type rsp_status_ff, rsp_status_in;
   logic       rsp_is_expiry_ff, rsp_is_expiry_in;
   id_type     rsp_id_ff, rsp_id_in;
   logic       rsp_last_ff, rsp_last_in;

   // RAM port
   logic                 wr_en, rd_en;
   addr_type             wr_addr, rd_addr;
   logic [ENTRY_W-1:0]   wr_data, rd_data;
   entry_type            rd_entry, new_entry;

   // Shared decode
   logic     accept;
   cmd_type  req_cmd_e;
   addr_type req_slot;
   logic     req_ok_id;
   logic     req_active;
   logic     idx_last;
   logic     idx_zero;
   logic     ins_greater;
   logic     rm_match;
   logic     tick_hit;

   function automatic addr_type pos_of(addr_type base, count_type l);
      return base + l[ADDR_W-1:0];
   endfunction

   setimer_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (RAM_DEPTH)
   ) u_order_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign busy       = (state_ff != ST_IDLE);
   assign accept     = start && !busy;
   assign req_cmd_e  = cmd_type'(req_cmd);
   assign req_slot   = to_slot(req_timer_id);
   assign req_ok_id  = id_in_range(req_timer_id);
   assign req_active = slot_active_ff[req_slot];

   assign rd_entry    = entry_type'(rd_data);
   assign new_entry   = '{expiry: exp_ff, id: id_ff};
   assign idx_last    = (idx_ff == (count_ff - COUNT_W'(1)));
   assign idx_zero    = (idx_ff == '0);
   assign ins_greater = (rd_entry.expiry > exp_ff);
   assign rm_match    = (rd_entry.id == id_ff);
   assign tick_hit    = (idx_ff < count_ff) && (32'(idx_ff) < MAX_POP) &&
                        (rd_entry.expiry <= now_ff);

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_cmd_e) inside
                  CMD_TICK: begin
                     state_in = ST_TICK;
                  end
                  CMD_ADD: begin
                     if (req_ok_id && !req_active) begin
                        state_in = ST_INS_INIT;
                     end
                  end
                  CMD_ADJUST, CMD_DELETE: begin
                     if (req_ok_id && req_active) begin
                        state_in = ST_RM_WALK;
                     end
                  end
               endcase
            end
         end
         ST_INS_INIT: begin
            state_in = (count_ff == '0) ? ST_IDLE : ST_INS_WALK;
         end
         ST_INS_WALK: begin
            if (!ins_greater) begin
               state_in = ST_IDLE;
            end else if (idx_zero) begin
               state_in = ST_INS_HEAD;
            end
         end
         ST_INS_HEAD: begin
            state_in = ST_IDLE;
         end
         ST_RM_WALK: begin
            if (idx_last) begin
               state_in = (cmd_ff == CMD_ADJUST) ? ST_INS_INIT : ST_IDLE;
            end
         end
         ST_TICK: begin
            if (!tick_hit) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Datapath, RAM accesses and result beats
   always_comb begin
      count_in         = count_ff;
      head_in          = head_ff;
      slot_active_in   = slot_active_ff;
      pend_in          = pend_ff;
      found_in         = found_ff;
      cmd_in           = cmd_ff;
      id_in            = id_ff;
      exp_in           = exp_ff;
      now_in           = now_ff;
      idx_in           = idx_ff;
      pend_id_in       = pend_id_ff;
      rsp_valid_in     = 1'b0;
      rsp_status_in    = rsp_status_ff;
      rsp_is_expiry_in = rsp_is_expiry_ff;
      rsp_id_in        = rsp_id_ff;
      rsp_last_in      = rsp_last_ff;
      wr_en            = 1'b0;
      wr_addr          = '0;
      wr_data          = '0;
      rd_en            = 1'b0;
      rd_addr          = '0;

      unique case (state_ff)
         // Latch the command; answer errors at once, start walks otherwise
         ST_IDLE: begin
            if (accept) begin
               cmd_in   = req_cmd_e;
               id_in    = req_timer_id;
               exp_in   = to_time(req_expire_time);
               now_in   = to_time(req_now_time);
               idx_in   = '0;
               found_in = 1'b0;
               pend_in  = 1'b0;
               unique case (req_cmd_e) inside
                  CMD_TICK: begin
                     rd_en   = 1'b1;
                     rd_addr = head_ff;
                  end
                  CMD_ADD: begin
                     if (!req_ok_id || req_active) begin
                        rsp_valid_in     = 1'b1;
                        rsp_status_in    = req_ok_id ? STATUS_ACTIVE : STATUS_INACTIVE;
                        rsp_is_expiry_in = 1'b0;
                        rsp_id_in        = '0;
                        rsp_last_in      = 1'b1;
                     end else begin
                        slot_active_in[req_slot] = 1'b1;
                     end
                  end
                  CMD_ADJUST, CMD_DELETE: begin
                     if (!req_ok_id || !req_active) begin
                        rsp_valid_in     = 1'b1;
                        rsp_status_in    = STATUS_INACTIVE;
                        rsp_is_expiry_in = 1'b0;
                        rsp_id_in        = '0;
                        rsp_last_in      = 1'b1;
                     end else begin
                        rd_en   = 1'b1;
                        rd_addr = head_ff;
                        if (req_cmd_e == CMD_DELETE) begin
                           slot_active_in[req_slot] = 1'b0;
                        end
                     end
                  end
               endcase
            end
         end

         // Place into an empty list, or fetch the tail to start the walk
         ST_INS_INIT: begin
            if (count_ff == '0) begin
               wr_en            = 1'b1;
               wr_addr          = head_ff;
               wr_data          = new_entry;
               count_in         = count_ff + COUNT_W'(1);
               rsp_valid_in     = 1'b1;
               rsp_status_in    = STATUS_OK;
               rsp_is_expiry_in = 1'b0;
               rsp_id_in        = '0;
               rsp_last_in      = 1'b1;
            end else begin
               rd_en   = 1'b1;
               rd_addr = pos_of(head_ff, count_ff - COUNT_W'(1));
               idx_in  = count_ff - COUNT_W'(1);
            end
         end

         // Shift later entries up one place; drop the new one behind equals
         ST_INS_WALK: begin
            wr_en   = 1'b1;
            wr_addr = pos_of(head_ff, idx_ff + COUNT_W'(1));
            if (ins_greater) begin
               wr_data = rd_data;
               if (!idx_zero) begin
                  rd_en   = 1'b1;
                  rd_addr = pos_of(head_ff, idx_ff - COUNT_W'(1));
                  idx_in  = idx_ff - COUNT_W'(1);
               end
            end else begin
               wr_data          = new_entry;
               count_in         = count_ff + COUNT_W'(1);
               rsp_valid_in     = 1'b1;
               rsp_status_in    = STATUS_OK;
               rsp_is_expiry_in = 1'b0;
               rsp_id_in        = '0;
               rsp_last_in      = 1'b1;
            end
         end

         // New entry becomes the head
         ST_INS_HEAD: begin
            wr_en            = 1'b1;
            wr_addr          = head_ff;
            wr_data          = new_entry;
            count_in         = count_ff + COUNT_W'(1);
            rsp_valid_in     = 1'b1;
            rsp_status_in    = STATUS_OK;
            rsp_is_expiry_in = 1'b0;
            rsp_id_in        = '0;
            rsp_last_in      = 1'b1;
         end

         // Find the id, then shift every later entry down one place
         ST_RM_WALK: begin
            if (found_ff) begin
               wr_en   = 1'b1;
               wr_addr = pos_of(head_ff, idx_ff - COUNT_W'(1));
               wr_data = rd_data;
            end else if (rm_match) begin
               found_in = 1'b1;
            end
            if (idx_last) begin
               count_in = count_ff - COUNT_W'(1);
               if (cmd_ff == CMD_DELETE) begin
                  rsp_valid_in     = 1'b1;
                  rsp_status_in    = STATUS_OK;
                  rsp_is_expiry_in = 1'b0;
                  rsp_id_in        = '0;
                  rsp_last_in      = 1'b1;
               end
            end else begin
               rd_en   = 1'b1;
               rd_addr = pos_of(head_ff, idx_ff + COUNT_W'(1));
               idx_in  = idx_ff + COUNT_W'(1);
            end
         end

         // Pop expired heads; hold each id in pend_id until the next read shows if it is last
         ST_TICK: begin
            if (tick_hit) begin
               if (pend_ff) begin
                  rsp_valid_in     = 1'b1;
                  rsp_status_in    = STATUS_OK;
                  rsp_is_expiry_in = 1'b1;
                  rsp_id_in        = pend_id_ff;
                  rsp_last_in      = 1'b0;
               end
               pend_in    = 1'b1;
               pend_id_in = rd_entry.id;
               slot_active_in[to_slot(rd_entry.id)] = 1'b0;
               rd_en   = 1'b1;
               rd_addr = pos_of(head_ff, idx_ff + COUNT_W'(1));
               idx_in  = idx_ff + COUNT_W'(1);
            end else begin
               rsp_valid_in     = 1'b1;
               rsp_status_in    = STATUS_OK;
               rsp_is_expiry_in = pend_ff;
               rsp_id_in        = pend_ff ? pend_id_ff : '0;
               rsp_last_in      = 1'b1;
               pend_in          = 1'b0;
               head_in          = pos_of(head_ff, idx_ff);
               count_in         = count_ff - idx_ff;
            end
         end

         default: begin
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         count_ff       <= '0;
         head_ff        <= '0;
         slot_active_ff <= '0;
         pend_ff        <= 1'b0;
         found_ff       <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         count_ff       <= count_in;
         head_ff        <= head_in;
         slot_active_ff <= slot_active_in;
         pend_ff        <= pend_in;
         found_ff       <= found_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      cmd_ff           <= cmd_in;
      id_ff            <= id_in;
      exp_ff           <= exp_in;
      now_ff           <= now_in;
      idx_ff           <= idx_in;
      pend_id_ff       <= pend_id_in;
      rsp_status_ff    <= rsp_status_in;
      rsp_is_expiry_ff <= rsp_is_expiry_in;
      rsp_id_ff        <= rsp_id_in;
      rsp_last_ff      <= rsp_last_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_is_expiry  = rsp_is_expiry_ff;
   assign rsp_expired_id = rsp_id_ff;
   assign rsp_last       = rsp_last_ff;

   // Checks
   `SETIMER_ASSERT(a_count_bound, clock, reset, (32'(count_ff) <= NUM_TIMERS), "entry count overflow")
   `SETIMER_ASSERT(a_idle_active, clock, reset, (!busy |-> ($countones(slot_active_ff) == 32'(count_ff))), "active bits disagree with entry count")
   `SETIMER_ASSERT(a_idle_last, clock, reset, ((rsp_valid && !busy) |-> rsp_last), "result beat after command end is not last")
   `SETIMER_ASSERT(a_ram_hazard, clock, reset, ((wr_en && rd_en) |-> (wr_addr != rd_addr)), "RAM read and write hit the same entry")

endmodule

FILE: tb/sv/tb_sorted_expiry_timer_table.sv
// Self-checking testbench for sorted_expiry_timer_table: a table of directed
// commands, then random add/adjust/delete/tick traffic, checked beat by beat.
// Depends on setimer_pkg and the sorted_expiry_timer_table RTL.
module tb_sorted_expiry_timer_table;
   import setimer_pkg::*;

   localparam int          DIRECTED_ROWS = 21;
   localparam int          RANDOM_IDLE   = 24;
   localparam int          RANDOM_TAIL   = 20;
   localparam int unsigned CYCLE_LIMIT   = 400_000;
   localparam int          DRAIN_CYCLES  = 2 * NUM_TIMERS + 8;

   // One result beat as the block shows it
   typedef struct packed {
      status_type status;
      logic       is_expiry;
      id_type     expired_id;
      logic       last;
   } rsp_beat_t;

   // One command of the directed table; beat holds the typed-in answer
   typedef struct packed {
      cmd_type              cmd;
      id_type               id;
      logic [IN_TIME_W-1:0] exp_t;
      logic [IN_TIME_W-1:0] now_t;
      logic                 typed;
      rsp_beat_t            beat;
   } stim_row_t;

   localparam rsp_beat_t BEAT_OK       = '{STATUS_OK, 1'b0, '0, 1'b1};
   localparam rsp_beat_t BEAT_ACTIVE   = '{STATUS_ACTIVE, 1'b0, '0, 1'b1};
   localparam rsp_beat_t BEAT_INACTIVE = '{STATUS_INACTIVE, 1'b0, '0, 1'b1};
   localparam rsp_beat_t NO_BEAT       = '0;

   logic                 clock;
   logic                 reset;
   logic                 start;
   logic                 busy;
   logic [1:0]           req_cmd;
   logic [ID_W-1:0]      req_timer_id;
   logic [IN_TIME_W-1:0] req_expire_time;
   logic [IN_TIME_W-1:0] req_now_time;
   logic                 rsp_valid;
   logic [1:0]           rsp_status;
   logic                 rsp_is_expiry;
   logic [ID_W-1:0]      rsp_expired_id;
   logic                 rsp_last;

   // Shadow of the timer list
   id_type                list_ids [NUM_TIMERS];
   time_type              slot_expiry [NUM_TIMERS];
   logic [NUM_TIMERS-1:0] slot_live;
   int                    list_len;

   rsp_beat_t   predicted_beats [$];
   rsp_beat_t   expected_beats [$];
   int          mismatch_count;
   int unsigned cycle_count;
   logic [31:0] now_base;

   sorted_expiry_timer_table dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_cmd         (req_cmd),
      .req_timer_id    (req_timer_id),
      .req_expire_time (req_expire_time),
      .req_now_time    (req_now_time),
      .rsp_valid       (rsp_valid),
      .rsp_status      (rsp_status),
      .rsp_is_expiry   (rsp_is_expiry),
      .rsp_expired_id  (rsp_expired_id),
      .rsp_last        (rsp_last)
   );

   always #5 clock = ~clock;

   // Place an id after every entry with equal or smaller expiry
   function automatic void list_insert(id_type id);
      int pos;
      pos = 0;
      if (list_len >= NUM_TIMERS) return;
      while (pos < list_len && slot_expiry[list_ids[pos]] <= slot_expiry[id]) pos++;
      for (int i = list_len; i > pos; i--) list_ids[i] = list_ids[i-1];
      list_ids[pos] = id;
      list_len++;
   endfunction

   function automatic void list_remove(id_type id);
      int pos;
      pos = 0;
      while (pos < list_len && list_ids[pos] != id) pos++;
      if (pos >= list_len) return;
      for (int i = pos; i + 1 < list_len; i++) list_ids[i] = list_ids[i+1];
      list_len--;
   endfunction

   // Apply one command to the shadow list and leave its beats in predicted_beats
   function automatic void predict_timer_beats(cmd_type cmd, id_type id,
                                               logic [IN_TIME_W-1:0] exp_in,
                                               logic [IN_TIME_W-1:0] now_in);
      time_type exp_t;
      time_type now_t;
      int       pops;
      exp_t = exp_in[TIME_WIDTH-1:0];
      now_t = now_in[TIME_WIDTH-1:0];
      predicted_beats.delete();
      if (cmd == CMD_TICK) begin
         pops = 0;
         while (pops < MAX_POP && pops < list_len &&
                slot_expiry[list_ids[pops]] <= now_t) pops++;
         if (pops == 0) begin
            predicted_beats.push_back(BEAT_OK);
         end else begin
            for (int i = 0; i < pops; i++) begin
               slot_live[list_ids[i]] = 1'b0;
               predicted_beats.push_back('{STATUS_OK, 1'b1, list_ids[i], i == pops - 1});
            end
            for (int i = 0; i + pops < list_len; i++) list_ids[i] = list_ids[i+pops];
            list_len -= pops;
         end
      end else if (int'(id) >= NUM_TIMERS) begin
         predicted_beats.push_back(BEAT_INACTIVE);
      end else if (cmd == CMD_ADD) begin
         if (slot_live[id]) begin
            predicted_beats.push_back(BEAT_ACTIVE);
         end else begin
            slot_expiry[id] = exp_t;
            slot_live[id]   = 1'b1;
            list_insert(id);
            predicted_beats.push_back(BEAT_OK);
         end
      end else if (!slot_live[id]) begin
         predicted_beats.push_back(BEAT_INACTIVE);
      end else begin
         list_remove(id);
         if (cmd == CMD_ADJUST) begin
            slot_expiry[id] = exp_t;
            list_insert(id);
         end else begin
            slot_live[id] = 1'b0;
         end
         predicted_beats.push_back(BEAT_OK);
      end
   endfunction

   // Directed commands: extremes, error codes, ties, adjust both ways, pops
   function automatic stim_row_t directed_row(int k);
      case (k)
         0:  return '{CMD_TICK,   6'd0,  32'd0,          32'd0,          1'b1, BEAT_OK};
         1:  return '{CMD_DELETE, 6'd5,  32'd0,          32'd0,          1'b1, BEAT_INACTIVE};
         2:  return '{CMD_ADJUST, 6'd63, 32'hFFFF_FFFF,  32'hFFFF_FFFF,  1'b1, BEAT_INACTIVE};
         3:  return '{CMD_ADD,    6'd0,  32'd0,          32'd0,          1'b1, BEAT_OK};
         4:  return '{CMD_ADD,    6'd0,  32'd5,          32'd0,          1'b1, BEAT_ACTIVE};
         5:  return '{CMD_ADD,    6'd63, 32'hFFFF_FFFF,  32'd0,          1'b1, BEAT_OK};
         6:  return '{CMD_ADD,    6'd10, 32'd100,        32'd0,          1'b0, NO_BEAT};
         7:  return '{CMD_ADD,    6'd11, 32'd100,        32'd0,          1'b0, NO_BEAT};
         8:  return '{CMD_ADD,    6'd12, 32'd50,         32'd0,          1'b0, NO_BEAT};
         9:  return '{CMD_ADJUST, 6'd10, 32'd20,         32'd0,          1'b0, NO_BEAT};
         10: return '{CMD_ADJUST, 6'd12, 32'd200,        32'd0,          1'b0, NO_BEAT};
         11: return '{CMD_ADJUST, 6'd11, 32'd100,        32'd0,          1'b0, NO_BEAT};
         12: return '{CMD_DELETE, 6'd11, 32'd0,          32'd0,          1'b0, NO_BEAT};
         13: return '{CMD_DELETE, 6'd11, 32'd0,          32'd0,          1'b1, BEAT_INACTIVE};
         14: return '{CMD_TICK,   6'd0,  32'd0,          32'd0,          1'b0, NO_BEAT};
         15: return '{CMD_ADD,    6'd1,  32'd300,        32'd0,          1'b0, NO_BEAT};
         16: return '{CMD_ADD,    6'd2,  32'd300,        32'd0,          1'b0, NO_BEAT};
         17: return '{CMD_TICK,   6'd0,  32'd0,          32'd99,         1'b0, NO_BEAT};
         18: return '{CMD_TICK,   6'd42, 32'hFFFF_FFFF,  32'hFFFF_FFFE,  1'b0, NO_BEAT};
         19: return '{CMD_TICK,   6'd0,  32'd0,          32'hFFFF_FFFF,  1'b0, NO_BEAT};
         default: return '{CMD_TICK, 6'd0, 32'd0,       32'hFFFF_FFFF,  1'b1, BEAT_OK};
      endcase
   endfunction

   // Find a slot that is live or free, starting at a random place
   function automatic int pick_slot(logic want_live);
      int base;
      base = $urandom_range(0, NUM_TIMERS - 1);
      for (int k = 0; k < NUM_TIMERS; k++)
         if (slot_live[(base + k) % NUM_TIMERS] == want_live) return (base + k) % NUM_TIMERS;
      return -1;
   endfunction

   // Drop start for an idle burst of random length
   task automatic pause_sender();
      int n;
      n = $urandom_range(1, 17);
      @(negedge clock);
      start = 1'b0;
      repeat (n - 1) @(negedge clock);
   endtask

   // Present one command beat, hold it until taken, then log its results
   task automatic send_command(cmd_type cmd, id_type id, logic [IN_TIME_W-1:0] exp_t,
                               logic [IN_TIME_W-1:0] now_t, logic typed, rsp_beat_t beat);
      @(negedge clock);
      start           = 1'b1;
      req_cmd         = cmd;
      req_timer_id    = id;
      req_expire_time = exp_t;
      req_now_time    = now_t;
      do @(posedge clock); while (busy);
      predict_timer_beats(cmd, id, exp_t, now_t);
      if (typed) expected_beats.push_back(beat);
      else foreach (predicted_beats[i]) expected_beats.push_back(predicted_beats[i]);
   endtask

   // Pick an expiry near the running time, a tie, or anything at all
   function automatic logic [31:0] pick_expiry();
      int q;
      int tie;
      q = $urandom_range(0, 9);
      tie = pick_slot(1'b1);
      if (q == 0) return $urandom();
      if (q < 3 && tie >= 0) return slot_expiry[tie];
      return now_base - 32'd10 + $urandom_range(0, 90);
   endfunction

   // Mostly well-formed commands on live or free slots, the rest noise
   task automatic random_command(logic allow_idle);
      int          r;
      int          slot;
      cmd_type     cmd;
      id_type      id;
      logic [31:0] exp_t;
      logic [31:0] now_t;
      if (allow_idle && $urandom_range(0, 3) == 0) pause_sender();
      r     = $urandom_range(0, 99);
      slot  = -1;
      id    = id_type'($urandom_range(0, NUM_TIMERS - 1));
      exp_t = $urandom();
      now_t = $urandom();
      cmd   = CMD_TICK;
      if (r < 35) begin
         slot = pick_slot(1'b0);
         cmd  = CMD_ADD;
      end else if (r < 50) begin
         slot = pick_slot(1'b1);
         cmd  = CMD_ADJUST;
      end else if (r < 62) begin
         slot = pick_slot(1'b1);
         cmd  = CMD_DELETE;
      end
      if (r < 62 && slot >= 0) begin
         id    = id_type'(slot);
         exp_t = pick_expiry();
      end else if (r < 84) begin
         // advance time and tick
         cmd      = CMD_TICK;
         now_base = now_base + $urandom_range(0, 40);
         now_t    = now_base;
      end else begin
         // noise: any command on any id
         case ($urandom_range(0, 3))
            0: cmd = CMD_ADD;
            1: cmd = CMD_ADJUST;
            2: cmd = CMD_DELETE;
            default: cmd = CMD_TICK;
         endcase
         if ($urandom_range(0, 1) == 0) now_t = now_base - $urandom_range(0, 50);
      end
      send_command(cmd, id, exp_t, now_t, 1'b0, NO_BEAT);
   endtask

   // Check every result beat against the oldest expectation
   always @(posedge clock) begin
      rsp_beat_t want;
      if (!reset && rsp_valid === 1'b1) begin
         if (expected_beats.size() == 0) begin
            $error("unexpected result beat: status %0d is_expiry %0d expired_id %0d last %0d",
                   rsp_status, rsp_is_expiry, rsp_expired_id, rsp_last);
            mismatch_count++;
         end else begin
            want = expected_beats.pop_front();
            if (rsp_status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_status);
               mismatch_count++;
            end
            if (rsp_is_expiry !== want.is_expiry) begin
               $error("is_expiry: expected %0d, got %0d", want.is_expiry, rsp_is_expiry);
               mismatch_count++;
            end
            if (rsp_expired_id !== want.expired_id) begin
               $error("expired_id: expected %0d, got %0d", want.expired_id, rsp_expired_id);
               mismatch_count++;
            end
            if (rsp_last !== want.last) begin
               $error("last: expected %0d, got %0d", want.last, rsp_last);
               mismatch_count++;
            end
         end
      end
   end

   // Stop a hung run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("sorted_expiry_timer_table: mismatch");
         $finish;
      end
   end

   initial begin
      stim_row_t row;
      clock           = 1'b0;
      reset           = 1'b1;
      start           = 1'b0;
      req_cmd         = '0;
      req_timer_id    = '0;
      req_expire_time = '0;
      req_now_time    = '0;
      slot_live       = '0;
      list_len        = 0;
      mismatch_count  = 0;
      cycle_count     = 0;
      now_base        = 32'd1000;

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Walk the directed table
      for (int k = 0; k < DIRECTED_ROWS; k++) begin
         row = directed_row(k);
         if ($urandom_range(0, 2) == 0) pause_sender();
         send_command(row.cmd, row.id, row.exp_t, row.now_t, row.typed, row.beat);
      end

      // Random traffic with idle bursts
      for (int k = 0; k < RANDOM_IDLE; k++) random_command(1'b1);

      // Hold off until every result is in
      @(negedge clock);
      start = 1'b0;
      while (expected_beats.size() != 0) @(posedge clock);

      // Drain, fill all slots with close expiries, then pop the whole list at once
      send_command(CMD_TICK, id_type'($urandom()), $urandom(), 32'hFFFF_FFFF, 1'b0, NO_BEAT);
      for (int s = 0; s < NUM_TIMERS; s++)
         if (!slot_live[s])
            send_command(CMD_ADD, id_type'(s), now_base + $urandom_range(0, 3), $urandom(),
                         1'b0, NO_BEAT);
      send_command(CMD_TICK, id_type'($urandom()), $urandom(), now_base + 32'd3, 1'b0, NO_BEAT);

      // Back-to-back random traffic
      for (int k = 0; k < RANDOM_TAIL; k++) random_command(1'b0);

      @(negedge clock);
      start = 1'b0;
      while (expected_beats.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("sorted_expiry_timer_table: match");
      end else begin
         $display("sorted_expiry_timer_table: mismatch");
      end
      $finish;
   end

endmodule
